### rtl/cts_pkg.sv
// Shared definitions for the Cartesian to spherical converter.
// Holds the working widths, the CORDIC arctangent table and the sideband type.
// Depends on nothing; every file of the block but cts_if uses it.
package cts_pkg;

   // Number of CORDIC iterations in each vectoring pass, and the table length.
   localparam int CORDIC_STAGES = 32;
   localparam int TABLE_LEN     = 41;
   localparam int PASS_STAGES   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

   // Fraction bits added to the coordinates, and the width of the datapath.
   // 46 bits holds the largest magnitude of the second pass with margin.
   localparam int GUARD_BITS = 8;
   localparam int WORK_W     = 46;
   localparam int HI_W       = WORK_W - 32;

   // Limit CORDIC inverse gain in Q32.
   localparam logic [31:0] INV_GAIN = 32'd2608131496;

   // Binary angle of pi.
   localparam logic [31:0] ANGLE_PI = 32'h8000_0000;

   // Items that travel beside the datapath through a vectoring pass.
   typedef struct packed {
      logic [31:0] word;
      logic        xy_zero;
      logic        all_zero;
   } cts_side_type;

   // round(atan(2^-i) * 2^31 / pi); the tail of the table is zero.
   function automatic logic [31:0] atan_entry(input int idx);
      logic [31:0] val;
      case (idx)
         0:       val = 32'd536870912;
         1:       val = 32'd316933406;
         2:       val = 32'd167458907;
         3:       val = 32'd85004756;
         4:       val = 32'd42667331;
         5:       val = 32'd21354465;
         6:       val = 32'd10679838;
         7:       val = 32'd5340245;
         8:       val = 32'd2670163;
         9:       val = 32'd1335087;
         10:      val = 32'd667544;
         11:      val = 32'd333772;
         12:      val = 32'd166886;
         13:      val = 32'd83443;
         14:      val = 32'd41722;
         15:      val = 32'd20861;
         16:      val = 32'd10430;
         17:      val = 32'd5215;
         18:      val = 32'd2608;
         19:      val = 32'd1304;
         20:      val = 32'd652;
         21:      val = 32'd326;
         22:      val = 32'd163;
         23:      val = 32'd81;
         24:      val = 32'd41;
         25:      val = 32'd20;
         26:      val = 32'd10;
         27:      val = 32'd5;
         28:      val = 32'd3;
         29:      val = 32'd1;
         30:      val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

### rtl/cts_if.sv
// Valid/ready channel interfaces for the converter's point and result words.
// Depends on nothing else in the block.
interface cts_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_coord;
   logic signed [31:0] y_coord;
   logic signed [31:0] z_coord;

   modport source (output valid, output x_coord, output y_coord, output z_coord,
                   input ready);
   modport sink (input valid, input x_coord, input y_coord, input z_coord,
                 output ready);
endinterface

interface cts_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] longitude;
   logic signed [31:0] latitude;
   logic        [31:0] distance;

   modport source (output valid, output longitude, output latitude, output distance,
                   input ready);
   modport sink (input valid, input longitude, input latitude, input distance,
                 output ready);
endinterface

### rtl/cts_vector.sv
// One pipelined CORDIC vectoring pass followed by the two-stage gain correction.
// Depends on cts_pkg for widths, the arctangent table and the sideband type.
module cts_vector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  logic signed [cts_pkg::WORK_W-1:0]   in_x,
   input  logic signed [cts_pkg::WORK_W-1:0]   in_y,
   input  logic        [31:0]                  in_angle,
   input  cts_pkg::cts_side_type               in_side,
   output logic                                out_valid,
   output logic        [cts_pkg::WORK_W-1:0]   out_mag,
   output logic        [31:0]                  out_angle,
   output cts_pkg::cts_side_type               out_side
);

   localparam int N = cts_pkg::PASS_STAGES;
   localparam int W = cts_pkg::WORK_W;
   localparam int H = cts_pkg::HI_W;

   // Stage registers of the iteration chain.
   logic signed [W-1:0]   x_ff    [N];
   logic signed [W-1:0]   y_ff    [N];
   logic        [31:0]    ang_ff  [N];
   cts_pkg::cts_side_type side_ff [N];
   logic        [N-1:0]   valid_ff;

   genvar k;
   for (k = 0; k < N; k++) begin : g_stage
      logic signed [W-1:0]   src_x;
      logic signed [W-1:0]   src_y;
      logic        [31:0]    src_ang;
      cts_pkg::cts_side_type src_side;
      logic                  src_valid;
      logic signed [W-1:0]   x_in;
      logic signed [W-1:0]   y_in;
      logic        [31:0]    ang_in;

      if (k == 0) begin : g_first
         assign src_x     = in_x;
         assign src_y     = in_y;
         assign src_ang   = in_angle;
         assign src_side  = in_side;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src_x     = x_ff[k-1];
         assign src_y     = y_ff[k-1];
         assign src_ang   = ang_ff[k-1];
         assign src_side  = side_ff[k-1];
         assign src_valid = valid_ff[k-1];
      end

      // Turn the vector towards the positive x axis by atan(2^-k).
      always_comb begin
         if (src_y[W-1]) begin
            x_in   = src_x - (src_y >>> k);
            y_in   = src_y + (src_x >>> k);
            ang_in = src_ang - cts_pkg::atan_entry(k);
         end else begin
            x_in   = src_x + (src_y >>> k);
            y_in   = src_y - (src_x >>> k);
            ang_in = src_ang + cts_pkg::atan_entry(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[k]    <= x_in;
            y_ff[k]    <= y_in;
            ang_ff[k]  <= ang_in;
            side_ff[k] <= src_side;
         end
      end
   end

   // Gain correction, first stage: the magnitude is non-negative here and is
   // split at bit 32 so that each product stays within 32 by 32 bits.
   logic [W-1:0]          x_last;
   logic [63:0]           lo_prod_in;
   logic [H+31:0]         hi_prod_in;
   logic [63:0]           lo_prod_ff;
   logic [H+31:0]         hi_prod_ff;
   logic [31:0]           gain_ang_ff;
   cts_pkg::cts_side_type gain_side_ff;
   logic                  gain_valid_ff;

   assign x_last     = x_ff[N-1];
   assign lo_prod_in = 64'(x_last[31:0]) * 64'(cts_pkg::INV_GAIN);
   assign hi_prod_in = (H+32)'(x_last[W-1:32]) * (H+32)'(cts_pkg::INV_GAIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_valid_ff <= 1'b0;
      end else if (enable) begin
         gain_valid_ff <= valid_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lo_prod_ff   <= lo_prod_in;
         hi_prod_ff   <= hi_prod_in;
         gain_ang_ff  <= ang_ff[N-1];
         gain_side_ff <= side_ff[N-1];
      end
   end

   // Gain correction, second stage: join the partial products, rounding half up.
   logic [64:0]           lo_round;
   logic [W:0]            mag_sum;
   logic [W-1:0]          mag_ff;
   logic [31:0]           mag_ang_ff;
   cts_pkg::cts_side_type mag_side_ff;
   logic                  mag_valid_ff;

   assign lo_round = {1'b0, lo_prod_ff} + 65'h0_8000_0000;
   assign mag_sum  = (W+1)'(hi_prod_ff) + (W+1)'(lo_round[64:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
      end else if (enable) begin
         mag_valid_ff <= gain_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff      <= mag_sum[W-1:0];
         mag_ang_ff  <= gain_ang_ff;
         mag_side_ff <= gain_side_ff;
      end
   end

   assign out_valid = mag_valid_ff;
   assign out_mag   = mag_ff;
   assign out_angle = mag_ang_ff;
   assign out_side  = mag_side_ff;

endmodule

### rtl/cartesian_to_spherical.sv
// Cartesian to spherical converter: top level with input and output registers.
// Depends on cts_pkg, the channel interfaces in cts_if and two cts_vector passes.
//
// Usage
//   A word on req_bus carries a point (x_coord, y_coord, z_coord) of signed
//   32-bit integers. Each word gives exactly one word on rsp_bus: longitude
//   (atan2(y, x), 2^31 stands for pi), latitude (elevation, 2^30 stands for
//   pi/2) and the unsigned distance, all in the order the points arrived.
//   The pipeline has one input register, two passes of CORDIC_STAGES
//   iteration registers plus two gain-correction registers each, and the
//   output register. Throughput is one word per cycle while the receiver
//   takes results; every iteration and multiplier stage holds its own item,
//   so the pipeline depth sets only the latency.
//   The whole pipeline advances together: when the output register holds a
//   word that the receiver does not take, every stage holds and req_bus.ready
//   falls, so nothing is dropped or repeated. The input is still taken while
//   the output register is empty.
//   Synchronous reset clears the valid bits of every stage; data in flight is
//   discarded. There is no configuration and no other state.
module cartesian_to_spherical (
   input logic      clock,
   input logic      reset,
   cts_req_if.sink  req_bus,
   cts_rsp_if.source rsp_bus
);

   localparam int W = cts_pkg::WORK_W;
   localparam int G = cts_pkg::GUARD_BITS;

   // Pipeline advance: the output register is empty or is being emptied.
   logic enable;
   logic rsp_valid_ff;

   assign enable        = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = enable;

   // Input stage: scale by the guard bits and fold negative x by turning pi.
   logic signed [W-1:0]   x_scaled;
   logic signed [W-1:0]   y_scaled;
   logic signed [W-1:0]   in_x_ff;
   logic signed [W-1:0]   in_y_ff;
   logic        [31:0]    in_ang_ff;
   cts_pkg::cts_side_type in_side_ff;
   logic                  in_valid_ff;

   assign x_scaled = {{(W-32-G){req_bus.x_coord[31]}}, req_bus.x_coord, G'(0)};
   assign y_scaled = {{(W-32-G){req_bus.y_coord[31]}}, req_bus.y_coord, G'(0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (enable) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (req_bus.x_coord[31]) begin
            in_x_ff   <= -x_scaled;
            in_y_ff   <= -y_scaled;
            in_ang_ff <= cts_pkg::ANGLE_PI;
         end else begin
            in_x_ff   <= x_scaled;
            in_y_ff   <= y_scaled;
            in_ang_ff <= 32'd0;
         end
         in_side_ff.word     <= req_bus.z_coord;
         in_side_ff.xy_zero  <= (req_bus.x_coord == 32'sd0) && (req_bus.y_coord == 32'sd0);
         in_side_ff.all_zero <= (req_bus.x_coord == 32'sd0) && (req_bus.y_coord == 32'sd0)
                                && (req_bus.z_coord == 32'sd0);
      end
   end

   // First pass: (x, y) onto the x axis gives longitude and horizontal radius.
   logic                  p1_valid;
   logic        [W-1:0]   p1_mag;
   logic        [31:0]    p1_angle;
   cts_pkg::cts_side_type p1_side;

   cts_vector u_pass_lon (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (in_valid_ff),
      .in_x      (in_x_ff),
      .in_y      (in_y_ff),
      .in_angle  (in_ang_ff),
      .in_side   (in_side_ff),
      .out_valid (p1_valid),
      .out_mag   (p1_mag),
      .out_angle (p1_angle),
      .out_side  (p1_side)
   );

   // Hand over to the second pass: z takes the place of y, longitude rides along.
   logic signed [W-1:0]   p2_x;
   logic signed [W-1:0]   p2_y;
   cts_pkg::cts_side_type p2_side;

   assign p2_x              = signed'(p1_mag);
   assign p2_y              = {{(W-32-G){p1_side.word[31]}}, p1_side.word, G'(0)};
   assign p2_side.word      = p1_side.xy_zero ? 32'd0 : p1_angle;
   assign p2_side.xy_zero   = p1_side.xy_zero;
   assign p2_side.all_zero  = p1_side.all_zero;

   // Second pass: (radius, z) onto the x axis gives latitude and distance.
   logic                  p2_valid;
   logic        [W-1:0]   p2_mag;
   logic        [31:0]    p2_angle;
   cts_pkg::cts_side_type p2_out_side;

   cts_vector u_pass_lat (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (p1_valid),
      .in_x      (p2_x),
      .in_y      (p2_y),
      .in_angle  (32'd0),
      .in_side   (p2_side),
      .out_valid (p2_valid),
      .out_mag   (p2_mag),
      .out_angle (p2_angle),
      .out_side  (p2_out_side)
   );

   // Output stage: clamp latitude, drop the guard bits of distance and saturate.
   logic signed [31:0] lat_raw;
   logic signed [31:0] lat_in;
   logic        [W:0]  dist_round;
   logic        [31:0] dist_in;
   logic signed [31:0] rsp_lon_ff;
   logic signed [31:0] rsp_lat_ff;
   logic        [31:0] rsp_dist_ff;

   assign lat_raw    = signed'(p2_angle);
   assign dist_round = (W+1)'(p2_mag) + (W+1)'(1 << (G-1));

   always_comb begin
      if (p2_out_side.all_zero) begin
         lat_in = 32'sd0;
      end else if (lat_raw > 32'sh4000_0000) begin
         lat_in = 32'sh4000_0000;
      end else if (lat_raw < -32'sh4000_0000) begin
         lat_in = -32'sh4000_0000;
      end else begin
         lat_in = lat_raw;
      end
   end

   always_comb begin
      if (|dist_round[W:G+32]) begin
         dist_in = 32'hFFFF_FFFF;
      end else begin
         dist_in = dist_round[G+31:G];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= p2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_lon_ff  <= signed'(p2_out_side.word);
         rsp_lat_ff  <= lat_in;
         rsp_dist_ff <= dist_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.longitude = rsp_lon_ff;
   assign rsp_bus.latitude  = rsp_lat_ff;
   assign rsp_bus.distance  = rsp_dist_ff;

endmodule

### dv/cts_checker.sv
// Result checker for the Cartesian to spherical converter testbench.
// Watches both channels, works out each expected result word and compares.
// Depends on cts_pkg for the stage count and on the channel interfaces in cts_if.
`timescale 1ns / 100ps

module cts_checker (
   input  logic clock,
   input  logic reset,
   cts_req_if   req_bus,
   cts_rsp_if   rsp_bus,
   output int   mismatches,
   output int   in_flight
);

   // Arctangent of 2^-i as a binary angle; the tail is zero.
   localparam int TAB_LEN = 41;
   localparam logic [31:0] ARCTAN [0:TAB_LEN-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
      32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
      32'd0,         32'd0,         32'd0,         32'd0,        32'd0,
      32'd0
   };
   localparam int STAGES = (cts_pkg::CORDIC_STAGES < TAB_LEN) ? cts_pkg::CORDIC_STAGES
                                                               : TAB_LEN;
   localparam int          FRAC_BITS    = 8;
   localparam logic [63:0] INV_GAIN_Q32 = 64'd2608131496;
   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam longint      QUARTER_TURN = 64'sd1 << 30;

   typedef struct packed {
      logic signed [31:0] longitude;
      logic signed [31:0] latitude;
      logic        [31:0] distance;
   } spherical_type;

   spherical_type spherical_due [$];
   int            failures = 0;
   int            words_seen = 0;

   assign mismatches = failures;

   // Prints one line per failure and keeps the tally.
   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      failures++;
   endtask

   // One vectoring pass: turns (vx, vy) onto the positive x axis, returns the angle.
   function automatic logic [31:0] vector_pass(inout longint vx, inout longint vy);
      longint      nx;
      longint      ny;
      logic [31:0] ang;
      ang = '0;
      for (int i = 0; i < STAGES; i++) begin
         if (vy < 0) begin
            nx  = vx - (vy >>> i);
            ny  = vy + (vx >>> i);
            ang = ang - ARCTAN[i];
         end else begin
            nx  = vx + (vy >>> i);
            ny  = vy - (vx >>> i);
            ang = ang + ARCTAN[i];
         end
         vx = nx;
         vy = ny;
      end
      return ang;
   endfunction

   // Multiplies a magnitude by the CORDIC inverse gain, rounding half up.
   function automatic logic [63:0] apply_inv_gain(input logic [63:0] mag);
      logic [63:0] hi;
      logic [63:0] lo;
      hi = mag >> 32;
      lo = {32'd0, mag[31:0]};
      return hi * INV_GAIN_Q32 + ((lo * INV_GAIN_Q32 + 64'h8000_0000) >> 32);
   endfunction

   // Spherical coordinates of one point, bit for bit as the block works them out.
   function automatic spherical_type to_spherical(input logic signed [31:0] x_in,
                                                  input logic signed [31:0] y_in,
                                                  input logic signed [31:0] z_in);
      longint             x0;
      longint             y0;
      longint             z0;
      longint             wx;
      longint             wy;
      longint             wz;
      longint             rad;
      longint             lat;
      logic signed [31:0] elev;
      logic [31:0]        lon;
      logic [31:0]        start;
      logic [63:0]        dist_full;
      spherical_type      res;
      x0    = x_in;
      y0    = y_in;
      z0    = z_in;
      wx    = x0 * (64'sd1 << FRAC_BITS);
      wy    = y0 * (64'sd1 << FRAC_BITS);
      start = '0;
      // A point with negative x is turned by pi before the first pass.
      if (wx < 0) begin
         wx    = -wx;
         wy    = -wy;
         start = HALF_TURN;
      end
      lon = start + vector_pass(wx, wy);
      if (x0 == 0 && y0 == 0) lon = '0;
      rad = longint'(apply_inv_gain(wx));

      // Second pass on (horizontal radius, z).
      wz   = z0 * (64'sd1 << FRAC_BITS);
      elev = vector_pass(rad, wz);
      lat  = elev;
      if (x0 == 0 && y0 == 0 && z0 == 0) lat = 0;
      if (lat > QUARTER_TURN) lat = QUARTER_TURN;
      if (lat < -QUARTER_TURN) lat = -QUARTER_TURN;

      dist_full = apply_inv_gain(rad);
      dist_full = (dist_full + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (dist_full > 64'h0000_0000_FFFF_FFFF) dist_full = 64'h0000_0000_FFFF_FFFF;

      res.longitude = lon;
      res.latitude  = lat[31:0];
      res.distance  = dist_full[31:0];
      return res;
   endfunction

   // Queue the expectation for every point taken, compare every result word taken.
   always @(posedge clock) begin : watch_words
      spherical_type got;
      spherical_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            spherical_due.push_back(to_spherical(req_bus.x_coord, req_bus.y_coord,
                                                 req_bus.z_coord));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.longitude = rsp_bus.longitude;
            got.latitude  = rsp_bus.latitude;
            got.distance  = rsp_bus.distance;
            if (spherical_due.size() == 0) begin
               report_mismatch($sformatf("result word %0d arrived with no point waiting",
                                         words_seen));
            end else begin
               want = spherical_due.pop_front();
               if (got.longitude !== want.longitude)
                  report_mismatch($sformatf("word %0d longitude %0d, expected %0d",
                                            words_seen, got.longitude, want.longitude));
               if (got.latitude !== want.latitude)
                  report_mismatch($sformatf("word %0d latitude %0d, expected %0d",
                                            words_seen, got.latitude, want.latitude));
               if (got.distance !== want.distance)
                  report_mismatch($sformatf("word %0d distance %0d, expected %0d",
                                            words_seen, got.distance, want.distance));
            end
            words_seen++;
         end
      end
      in_flight <= spherical_due.size();
   end

endmodule

### dv/tb.sv
// Testbench top for the Cartesian to spherical converter.
// Drives points and result back-pressure, and gives the verdict; cts_checker does the checking.
// Depends on cts_pkg, cts_if, the cartesian_to_spherical block and dv/cts_checker.sv.
`timescale 1ns / 100ps

module tb;

   localparam int RANDOM_POINTS = 950;
   localparam int CALM_POINTS   = 100;
   localparam int DRAIN_AT      = 600;
   localparam int LONG_HOLD_AT  = 250;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 200;
   localparam int STALL_LIMIT   = 2000;

   localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   in_flight;
   int   points_sent = 0;
   bit   calm_tail   = 1'b0;

   cts_req_if req_bus ();
   cts_rsp_if rsp_bus ();

   cartesian_to_spherical u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   cts_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .mismatches (mismatches),
      .in_flight  (in_flight)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Offers one point and holds it until the block takes the word.
   task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z);
      req_bus.x_coord <= x;
      req_bus.y_coord <= y;
      req_bus.z_coord <= z;
      req_bus.valid   <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      points_sent++;
   endtask

   // A coordinate drawn from a mix of full range, small values, zero, edges and signed powers of two.
   function automatic logic signed [31:0] random_coord();
      logic signed [31:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: c = $urandom;
         5, 6: begin
            c = $urandom_range(0, 2000);
            c = c - 1000;
         end
         7: c = '0;
         8: begin
            case ($urandom_range(0, 3))
               0:       c = C_MIN;
               1:       c = C_MAX;
               2:       c = -1;
               default: c = 1;
            endcase
         end
         default: begin
            c = 32'sd1 <<< $urandom_range(0, 30);
            if ($urandom_range(0, 1) == 1) c = -c;
         end
      endcase
      return c;
   endfunction

   // Points, with sender gaps and one pause until everything has come back.
   initial begin : stimulus
      int gap_odds;
      req_bus.valid   <= 1'b0;
      req_bus.x_coord <= '0;
      req_bus.y_coord <= '0;
      req_bus.z_coord <= '0;
      reset           <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Origin, axes, the angle pi, negative x and the extremes of every field.
      send_point(0, 0, 0);
      send_point(0, 0, 1);
      send_point(0, 0, -1);
      send_point(0, 0, C_MAX);
      send_point(0, 0, C_MIN);
      send_point(1, 0, 0);
      send_point(-1, 0, 0);
      send_point(C_MIN, 0, 0);
      send_point(C_MAX, 0, 0);
      send_point(0, 1, 0);
      send_point(0, -1, 0);
      send_point(0, C_MIN, 0);
      send_point(C_MIN, C_MIN, C_MIN);
      send_point(C_MAX, C_MAX, C_MAX);
      send_point(C_MIN, C_MAX, C_MAX);
      send_point(C_MAX, C_MIN, C_MIN);
      send_point(C_MIN, C_MIN, C_MAX);
      send_point(C_MAX, 0, C_MIN);
      send_point(-5, -7, 3);
      send_point(1, 1, 1);
      send_point(-1, -1, -1);
      send_point(-1, 1, 0);
      send_point(32'sh0000_FFFF, 32'sh7FFF_0000, -32'sd65536);

      // Random points; the odds of a gap are drawn anew every fifty words.
      gap_odds = 10;
      for (int n = 0; n < RANDOM_POINTS; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_odds = 0;
               1:       gap_odds = 12;
               default: gap_odds = 35;
            endcase
         end
         if (n == RANDOM_POINTS - CALM_POINTS) calm_tail = 1'b1;
         send_point(random_coord(), random_coord(), random_coord());
         if (n == DRAIN_AT) begin
            // Wait for the next edge so that the count includes the word just taken.
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (in_flight != 0) @(posedge clock);
         end else if (!calm_tail && $urandom_range(0, 99) < gap_odds) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      req_bus.valid <= 1'b0;

      // Let every expected word come back, then wait out the pipeline once more.
      while (in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && in_flight == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result back-pressure: random bursts, and one long hold that fills the pipeline.
   initial begin : receiver
      bit long_hold_done;
      int stall_odds;
      rsp_bus.ready <= 1'b0;
      long_hold_done = 1'b0;
      stall_odds     = 10;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!long_hold_done && points_sent >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm_tail && $urandom_range(0, 99) < stall_odds) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 63) == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_odds = 0;
               1:       stall_odds = 10;
               default: stall_odds = 40;
            endcase
         end
      end
   end

   // Ends the run if no word moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule
